>>> src/assert_macros.svh
// Assertion macros shared by the grid cell point labeler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GCPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that forces another condition on the following clock edge.
`define GCPL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/gcpl_pkg.sv
// Shared constants, types and bundles of the grid cell point labeler.
`timescale 1ns / 1ps

package gcpl_pkg;

	// Table geometry: entry k lives in lane k % NUM_CELLS at row k / NUM_CELLS.
	localparam int MAX_CELLS       = 4096;
	localparam int CELL_INDEX_BITS = 16;
	localparam int NUM_CELLS       = 16;
	localparam int LANE_W          = $clog2(NUM_CELLS);
	localparam int ROWS            = (MAX_CELLS + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W           = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ENTRY_W         = ROW_W + LANE_W;
	localparam int ISSUE_W         = ROW_W + 1;
	localparam int CNT_W           = $clog2(MAX_CELLS + 1);
	localparam int KEY_W           = 2 * CELL_INDEX_BITS;

	// Fixed field widths.
	localparam int COORD_W      = 32;
	localparam int SIZE_W       = 31;
	localparam int CELL_TOTAL_W = 13;
	localparam int LABEL_ID_W   = 16;
	localparam int LABEL_SHIFT  = 16;
	localparam int DIV_STEPS    = COORD_W;
	localparam int STEP_W       = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 2;

	typedef logic [LANE_W-1:0]          lane_t;
	typedef logic [ROW_W-1:0]           row_t;
	typedef logic [ENTRY_W-1:0]         entry_t;
	typedef logic [ISSUE_W-1:0]         issue_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [KEY_W-1:0]           key_t;
	typedef logic signed [CELL_INDEX_BITS-1:0] idx_t;
	typedef logic [CELL_TOTAL_W-1:0]    total_t;
	typedef logic [LABEL_ID_W-1:0]      label_id_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_GROUND_LIMIT = cfg_idx_t'(0);
	localparam cfg_idx_t REG_CELL_SIZE    = cfg_idx_t'(1);

	localparam logic signed [COORD_W-1:0] GROUND_LIMIT_RESET = '0;
	localparam logic [SIZE_W-1:0]         CELL_SIZE_RESET    = SIZE_W'(65536);

	// Saturation bounds of a cell index, seen from the quotient magnitude.
	localparam logic [COORD_W-1:0] QUO_POS_LIMIT = COORD_W'(2 ** (CELL_INDEX_BITS - 1) - 1);
	localparam logic [COORD_W:0]   QUO_NEG_LIMIT = (COORD_W + 1)'(2 ** (CELL_INDEX_BITS - 1));
	localparam idx_t IDX_MAX = {1'b0, {(CELL_INDEX_BITS - 1){1'b1}}};
	localparam idx_t IDX_MIN = {1'b1, {(CELL_INDEX_BITS - 1){1'b0}}};

	// A search probe that walks the chain of table cells, one cell a cycle.
	typedef struct packed {
		logic  valid;
		key_t  key;
		row_t  row;
		logic  hit;
		lane_t lane;
	} probe_t;

	// Insertion of a new key, broadcast to all cells.
	typedef struct packed {
		logic  en;
		lane_t lane;
		row_t  row;
		key_t  key;
	} wr_t;

endpackage

>>> src/gcpl_div.sv
// Iterative floor divider producing one saturated grid cell index.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcpl_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [gcpl_pkg::COORD_W-1:0]    dividend,
	input  logic [gcpl_pkg::SIZE_W-1:0]            divisor,
	output logic                                   done,
	output gcpl_pkg::idx_t                         index
);

	typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} dv_state_t;

	dv_state_t                     state_q;
	gcpl_pkg::step_t               step_q;
	logic [gcpl_pkg::COORD_W-1:0]  quo_q;
	logic [gcpl_pkg::SIZE_W-1:0]   rem_q;
	logic [gcpl_pkg::SIZE_W-1:0]   dvs_q;
	logic                          neg_q;
	logic                          done_q;
	gcpl_pkg::idx_t                index_q;

	logic [gcpl_pkg::COORD_W-1:0]  rem_sh;
	logic [gcpl_pkg::COORD_W-1:0]  rem_sub;
	logic                          rem_ge;
	logic [gcpl_pkg::COORD_W:0]    neg_mag;
	gcpl_pkg::idx_t                index_fix;

	// One restoring step: the dividend bits leave quo_q at the top while
	// quotient bits enter at the bottom.
	always_comb begin
		rem_sh  = {rem_q, quo_q[gcpl_pkg::COORD_W-1]};
		rem_ge  = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Floor toward minus infinity for negative dividends, then saturate.
	always_comb begin
		neg_mag = {1'b0, quo_q} + (gcpl_pkg::COORD_W + 1)'(rem_q != '0);
		if (!neg_q) begin
			if (quo_q > gcpl_pkg::QUO_POS_LIMIT) begin
				index_fix = gcpl_pkg::IDX_MAX;
			end else begin
				index_fix = gcpl_pkg::idx_t'(quo_q);
			end
		end else begin
			if (neg_mag > gcpl_pkg::QUO_NEG_LIMIT) begin
				index_fix = gcpl_pkg::IDX_MIN;
			end else begin
				index_fix = gcpl_pkg::idx_t'((gcpl_pkg::COORD_W + 1)'(0) - neg_mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dvs_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			index_q <= '0;
		end else begin
			done_q <= (state_q == DV_FIX);
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						neg_q   <= dividend[gcpl_pkg::COORD_W-1];
						quo_q   <= dividend[gcpl_pkg::COORD_W-1] ?
							gcpl_pkg::COORD_W'(0) - dividend : dividend;
						rem_q   <= '0;
						dvs_q   <= (divisor == '0) ? gcpl_pkg::SIZE_W'(1) : divisor;
						step_q  <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q  <= rem_ge ? rem_sub[gcpl_pkg::SIZE_W-1:0] :
						rem_sh[gcpl_pkg::SIZE_W-1:0];
					quo_q  <= {quo_q[gcpl_pkg::COORD_W-2:0], rem_ge};
					step_q <= step_q + gcpl_pkg::step_t'(1);
					if (step_q == gcpl_pkg::step_t'(gcpl_pkg::DIV_STEPS - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					index_q <= index_fix;
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign index = index_q;

	`GCPL_ASSERT(a_start_idle, !start || state_q == DV_IDLE, "divider started while busy")

endmodule

>>> src/gcpl_cell.sv
// One cell of the table chain: a bank of stored keys and one compare stage.
`timescale 1ns / 1ps

module gcpl_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gcpl_pkg::lane_t   lane_id,
	input  gcpl_pkg::cnt_t    count,
	input  gcpl_pkg::wr_t     wr,
	input  gcpl_pkg::probe_t  probe_in,
	output gcpl_pkg::probe_t  probe_out
);

	gcpl_pkg::key_t   mem [gcpl_pkg::ROWS];
	gcpl_pkg::key_t   rd_q;
	gcpl_pkg::probe_t probe_q;
	logic             in_range;

	// The bank is read at the row of the incoming probe; the registered data lines up
	// with the probe register.
	always_ff @(posedge clk) begin
		if (wr.en && wr.lane == lane_id) begin
			mem[wr.row] <= wr.key;
		end
		rd_q <= mem[probe_in.row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_in;
		end
	end

	// Only entries below the fill count hold keys of this frame.
	always_comb begin
		in_range  = {1'b0, probe_q.row, lane_id} < (gcpl_pkg::ENTRY_W + 1)'(count);
		probe_out = probe_q;
		if (probe_q.valid && !probe_q.hit && in_range && rd_q == probe_q.key) begin
			probe_out.hit  = 1'b1;
			probe_out.lane = lane_id;
		end
	end

endmodule

>>> src/grid_cell_point_labeler.sv
// Top level of the grid cell point labeler: control, counters and the cell chain.
//
// Points arrive on the point channel (pos_x, pos_y, pos_z in signed Q16.16 and
// frame_end); each point gives exactly one transaction on the result channel.
// Both channels move a transaction at a clock edge where valid is high and stall
// is low. Registers are written over the cfg channel (cfg_ready is always high);
// the user must write them only while the block is idle; the block does not
// enforce this. Index 0 is the ground height limit, index 1 the cell size;
// writes to other indexes are dropped. Processing is one point at a time. A
// ground point goes from idle straight to the finish state, which registers
// its result. Any other point runs two 32-step dividers, then sweeps the table
// as r rows of 16 entries through a chain of 16 cells, r = ceil(n/16) with n
// the cells assigned in the frame, before the finish state; with an empty table
// it skips the sweep. The next point is taken once the block is idle again.
// The result sits in an output register: the next point is accepted while the
// previous result still waits under result_stall, and only the finish of that
// next point waits for the register to free up.
// Reset clears the counters, the fill count and both registers to their
// defaults; the table needs no clearing since only filled entries are compared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_cell_point_labeler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Point channel.
	input  logic                                  point_valid,
	output logic                                  point_stall,
	input  logic signed [gcpl_pkg::COORD_W-1:0]   pos_x,
	input  logic signed [gcpl_pkg::COORD_W-1:0]   pos_y,
	input  logic signed [gcpl_pkg::COORD_W-1:0]   pos_z,
	input  logic                                  frame_end,
	// Result channel.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic                                  ground_flag,
	output logic [gcpl_pkg::COORD_W-1:0]          point_label,
	output logic                                  overflow_flag,
	output logic [gcpl_pkg::COORD_W-1:0]          ground_total,
	output gcpl_pkg::total_t                      cell_total,
	output logic                                  frame_done,
	// Configuration channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  gcpl_pkg::cfg_idx_t                    cfg_index,
	input  logic [gcpl_pkg::COORD_W-1:0]          cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_SEARCH, ST_FINISH} state_t;

	state_t                               state_q;
	logic signed [gcpl_pkg::COORD_W-1:0]  glimit_q;
	logic [gcpl_pkg::SIZE_W-1:0]          csize_q;
	logic                                 fend_q;
	logic                                 ground_q;
	gcpl_pkg::key_t                       key_q;
	gcpl_pkg::issue_t                     rows_q;
	gcpl_pkg::issue_t                     issue_q;
	gcpl_pkg::issue_t                     exit_q;
	logic                                 found_q;
	gcpl_pkg::entry_t                     hit_q;
	gcpl_pkg::cnt_t                       count_q;
	logic [gcpl_pkg::COORD_W-1:0]         gcnt_q;

	logic                                 result_valid_q;
	logic                                 ground_flag_q;
	logic [gcpl_pkg::COORD_W-1:0]         label_q;
	logic                                 ovf_q;
	logic [gcpl_pkg::COORD_W-1:0]         gtotal_q;
	gcpl_pkg::total_t                     ctotal_q;
	logic                                 fdone_q;

	logic                                 accept;
	logic                                 z_at_ground;
	logic                                 div_start;
	logic                                 done_x;
	logic                                 done_y;
	gcpl_pkg::idx_t                       idx_x;
	gcpl_pkg::idx_t                       idx_y;
	gcpl_pkg::issue_t                     rows_need;
	gcpl_pkg::probe_t                     chain [gcpl_pkg::NUM_CELLS + 1];
	gcpl_pkg::probe_t                     tail;
	gcpl_pkg::wr_t                        wr;
	logic                                 out_free;
	logic                                 commit;
	logic                                 is_full;
	logic                                 take_new;
	gcpl_pkg::label_id_t                  lbl_id;
	logic [gcpl_pkg::COORD_W-1:0]         gcnt_next;
	gcpl_pkg::cnt_t                       count_next;

	assign point_stall  = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign accept       = point_valid && !point_stall;
	assign z_at_ground  = pos_z <= glimit_q;
	assign div_start    = accept && !z_at_ground;

	// Both coordinates are divided side by side and finish together.
	gcpl_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pos_x),
		.divisor  (csize_q),
		.done     (done_x),
		.index    (idx_x)
	);

	gcpl_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pos_y),
		.divisor  (csize_q),
		.done     (done_y),
		.index    (idx_y)
	);

	// Number of table rows that hold at least one filled entry.
	assign rows_need = gcpl_pkg::issue_t'(({1'b0, count_q} +
		(gcpl_pkg::CNT_W + 1)'(gcpl_pkg::NUM_CELLS - 1)) >> gcpl_pkg::LANE_W);

	// A new probe enters the chain every search cycle until all rows are issued.
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = (state_q == ST_SEARCH) && (issue_q < rows_q);
		chain[0].key   = key_q;
		chain[0].row   = gcpl_pkg::row_t'(issue_q);
	end

	for (genvar gi = 0; gi < gcpl_pkg::NUM_CELLS; gi++) begin : g_cell
		gcpl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.lane_id   (gcpl_pkg::lane_t'(gi)),
			.count     (count_q),
			.wr        (wr),
			.probe_in  (chain[gi]),
			.probe_out (chain[gi + 1])
		);
	end

	assign tail = chain[gcpl_pkg::NUM_CELLS];

	// Result formation and table update at the end of a point.
	assign out_free = !result_valid_q || !result_stall;
	assign commit   = (state_q == ST_FINISH) && out_free;
	assign is_full  = (count_q == gcpl_pkg::cnt_t'(gcpl_pkg::MAX_CELLS));
	assign take_new = !ground_q && !found_q && !is_full;

	always_comb begin
		wr.en   = commit && take_new;
		wr.lane = gcpl_pkg::lane_t'(count_q);
		wr.row  = gcpl_pkg::row_t'(count_q >> gcpl_pkg::LANE_W);
		wr.key  = key_q;
	end

	always_comb begin
		if (found_q) begin
			lbl_id = gcpl_pkg::label_id_t'(hit_q) + gcpl_pkg::label_id_t'(1);
		end else begin
			lbl_id = gcpl_pkg::label_id_t'(count_q) + gcpl_pkg::label_id_t'(1);
		end
		gcnt_next  = ground_q ? gcnt_q + gcpl_pkg::COORD_W'(1) : gcnt_q;
		count_next = take_new ? count_q + gcpl_pkg::cnt_t'(1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			glimit_q       <= gcpl_pkg::GROUND_LIMIT_RESET;
			csize_q        <= gcpl_pkg::CELL_SIZE_RESET;
			fend_q         <= 1'b0;
			ground_q       <= 1'b0;
			key_q          <= '0;
			rows_q         <= '0;
			issue_q        <= '0;
			exit_q         <= '0;
			found_q        <= 1'b0;
			hit_q          <= '0;
			count_q        <= '0;
			gcnt_q         <= '0;
			result_valid_q <= 1'b0;
			ground_flag_q  <= 1'b0;
			label_q        <= '0;
			ovf_q          <= 1'b0;
			gtotal_q       <= '0;
			ctotal_q       <= '0;
			fdone_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					gcpl_pkg::REG_GROUND_LIMIT: glimit_q <= cfg_data;
					gcpl_pkg::REG_CELL_SIZE:    csize_q  <= cfg_data[gcpl_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end

			// A result that leaves while a new one is formed is replaced below.
			if (result_valid_q && !result_stall && !commit) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fend_q   <= frame_end;
						ground_q <= z_at_ground;
						found_q  <= 1'b0;
						state_q  <= z_at_ground ? ST_FINISH : ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (done_x) begin
						key_q   <= {idx_x, idx_y};
						rows_q  <= rows_need;
						issue_q <= '0;
						exit_q  <= '0;
						state_q <= (rows_need == '0) ? ST_FINISH : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (chain[0].valid) begin
						issue_q <= issue_q + gcpl_pkg::issue_t'(1);
					end
					// Rows leave the chain in order, so the first hit seen is
					// the lowest matching entry.
					if (tail.valid) begin
						exit_q <= exit_q + gcpl_pkg::issue_t'(1);
						if (tail.hit && !found_q) begin
							found_q <= 1'b1;
							hit_q   <= {tail.row, tail.lane};
						end
						if (exit_q == rows_q - gcpl_pkg::issue_t'(1)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						ground_flag_q  <= ground_q;
						ovf_q          <= !ground_q && !found_q && is_full;
						if (ground_q || (!found_q && is_full)) begin
							label_q <= '0;
						end else begin
							label_q <= {lbl_id, {gcpl_pkg::LABEL_SHIFT{1'b0}}};
						end
						gtotal_q <= gcnt_next;
						ctotal_q <= gcpl_pkg::total_t'(count_next);
						fdone_q  <= fend_q;
						// The last point of a frame empties the table afterwards.
						count_q  <= fend_q ? '0 : count_next;
						gcnt_q   <= fend_q ? '0 : gcnt_next;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign ground_flag    = ground_flag_q;
	assign point_label    = label_q;
	assign overflow_flag  = ovf_q;
	assign ground_total   = gtotal_q;
	assign cell_total     = ctotal_q;
	assign frame_done     = fdone_q;

	`GCPL_ASSERT(a_div_lockstep, done_x == done_y, "coordinate dividers out of step")
	`GCPL_ASSERT(a_count_bound, count_q <= gcpl_pkg::cnt_t'(gcpl_pkg::MAX_CELLS), "count overrun")
	`GCPL_ASSERT(a_drain_order, exit_q <= issue_q, "more probes left the chain than entered")
	`GCPL_ASSERT_NEXT(a_frame_clear, commit && fend_q, count_q == '0 && gcnt_q == '0, "no clear")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the grid cell point labeler: directed, table-fill and random frames.
`timescale 1ns / 1ps

module testbench;

	// One point as it goes into the block, and the labeling that it should get back.
	typedef struct packed {
		logic signed [gcpl_pkg::COORD_W-1:0] x;
		logic signed [gcpl_pkg::COORD_W-1:0] y;
		logic signed [gcpl_pkg::COORD_W-1:0] z;
		logic                                fend;
	} point_t;

	typedef struct packed {
		logic                         ground;
		logic [gcpl_pkg::COORD_W-1:0] label;
		logic                         ovf;
		logic [gcpl_pkg::COORD_W-1:0] ground_cnt;
		gcpl_pkg::total_t             cells;
		logic                         done;
	} labeling_t;

	// Register indexes beyond the two real ones; the block must drop writes to these.
	localparam gcpl_pkg::cfg_idx_t REG_SPARE_A = gcpl_pkg::cfg_idx_t'(2);
	localparam gcpl_pkg::cfg_idx_t REG_SPARE_B = gcpl_pkg::cfg_idx_t'(3);

	localparam logic signed [gcpl_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [gcpl_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam logic [gcpl_pkg::SIZE_W-1:0]         SIZE_MAX  = 31'h7FFF_FFFF;
	localparam longint                              ONE_METER = 65536;

	// About 800 points are sent in all, so this limit is many times what the slowest
	// legal run needs.
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 point_valid;
	logic                 point_stall;
	logic signed [31:0]   pos_x;
	logic signed [31:0]   pos_y;
	logic signed [31:0]   pos_z;
	logic                 frame_end;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 ground_flag;
	logic [31:0]          point_label;
	logic                 overflow_flag;
	logic [31:0]          ground_total;
	gcpl_pkg::total_t     cell_total;
	logic                 frame_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	gcpl_pkg::cfg_idx_t   cfg_index;
	logic [31:0]          cfg_data;

	// Shadow copy of the block's registers and frame state, advanced at each accepted point.
	logic signed [gcpl_pkg::COORD_W-1:0] ground_limit;
	logic [gcpl_pkg::SIZE_W-1:0]         cell_edge;
	int unsigned                         seen_keys[gcpl_pkg::key_t];
	int unsigned                         cells_used;
	logic [gcpl_pkg::COORD_W-1:0]        ground_seen;

	// Labelings still owed by the block, oldest first.
	labeling_t   pending_labels[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Sender burst state and a switch that turns off idling on both channels.
	int unsigned burst_left;
	bit          quiet_mode;

	// Receiver stall pattern: a mode is held for a random stretch of cycles.
	int unsigned stall_mode = 0;
	int unsigned stall_hold = 0;

	grid_cell_point_labeler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.point_valid   (point_valid),
		.point_stall   (point_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.frame_end     (frame_end),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.ground_flag   (ground_flag),
		.point_label   (point_label),
		.overflow_flag (overflow_flag),
		.ground_total  (ground_total),
		.cell_total    (cell_total),
		.frame_done    (frame_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run is cut off here if the block hangs or stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result stall generator. Mode 0 never stalls, mode 1 stalls now and then and
	// mode 2 stalls most of the time, so the output register is kept full for long
	// stretches while the next point is already being worked on.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_hold <= $urandom_range(16, 96);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		if (quiet_mode || stall_mode == 0) begin
			result_stall <= 1'b0;
		end else if (stall_mode == 1) begin
			result_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			result_stall <= ($urandom_range(0, 7) != 0);
		end
	end

	// Floor division of a raw Q16.16 coordinate by the cell edge, saturated to the
	// signed cell index range. The Q16.16 scales cancel, so the raw integers are used.
	function automatic logic [gcpl_pkg::CELL_INDEX_BITS-1:0] grid_index(
			input logic signed [31:0] pos);
		longint coord;
		longint step;
		longint quo;
		coord = pos;
		step  = (cell_edge == '0) ? 64'sd1 : longint'(cell_edge);
		quo   = coord / step;
		// Division truncates toward zero; a negative coordinate with a remainder
		// must round down one more step.
		if ((coord % step != 0) && (coord < 0)) begin
			quo = quo - 1;
		end
		if (quo > longint'(gcpl_pkg::IDX_MAX)) begin
			quo = longint'(gcpl_pkg::IDX_MAX);
		end
		if (quo < longint'(gcpl_pkg::IDX_MIN)) begin
			quo = longint'(gcpl_pkg::IDX_MIN);
		end
		return quo[gcpl_pkg::CELL_INDEX_BITS-1:0];
	endfunction

	// Works out the labeling of one accepted point and advances the frame state.
	function automatic labeling_t label_point(input point_t p);
		labeling_t      r;
		gcpl_pkg::key_t cell_key;
		r      = '0;
		r.done = p.fend;
		if ($signed(p.z) <= $signed(ground_limit)) begin
			r.ground    = 1'b1;
			ground_seen = ground_seen + 1;
		end else begin
			cell_key = {grid_index(p.x), grid_index(p.y)};
			if (seen_keys.exists(cell_key)) begin
				r.label = (seen_keys[cell_key] & 32'hFFFF) << gcpl_pkg::LABEL_SHIFT;
			end else if (cells_used < gcpl_pkg::MAX_CELLS) begin
				// First sight of this cell in the frame: it takes the next id.
				cells_used          = cells_used + 1;
				seen_keys[cell_key] = cells_used;
				r.label             = (cells_used & 32'hFFFF) << gcpl_pkg::LABEL_SHIFT;
			end else begin
				// Table full: the cell is not stored and gets no id.
				r.ovf = 1'b1;
			end
		end
		r.ground_cnt = ground_seen;
		r.cells      = gcpl_pkg::total_t'(cells_used);
		// The last point of a frame still reports the totals, then the frame starts over.
		if (p.fend) begin
			seen_keys.delete();
			cells_used  = 0;
			ground_seen = '0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// Result checker: every result transaction is held against the oldest labeling owed.
	always @(posedge clk) begin
		labeling_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_labels.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transaction with no point outstanding, label %h",
					$time, point_label);
			end else begin
				want = pending_labels.pop_front();
				check_field("ground_flag", 32'(want.ground), 32'(ground_flag));
				check_field("point_label", want.label, point_label);
				check_field("overflow_flag", 32'(want.ovf), 32'(overflow_flag));
				check_field("ground_total", want.ground_cnt, ground_total);
				check_field("cell_total", 32'(want.cells), 32'(cell_total));
				check_field("frame_done", 32'(want.done), 32'(frame_done));
			end
		end
	end

	function automatic point_t make_point(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z, input logic fend);
		point_t p;
		p.x    = x;
		p.y    = y;
		p.z    = z;
		p.fend = fend;
		return p;
	endfunction

	// A value within span of center, clamped to the 32-bit signed range.
	function automatic logic signed [31:0] near_value(input longint center, input longint span);
		longint v;
		v = center + longint'($urandom_range(0, 32'(2 * span))) - span;
		if (v > longint'(COORD_MAX)) begin
			v = longint'(COORD_MAX);
		end
		if (v < longint'(COORD_MIN)) begin
			v = longint'(COORD_MIN);
		end
		return v[31:0];
	endfunction

	// Random point: mostly clustered around the origin so that cells repeat, some spread
	// wide so that new ids keep coming, and some anywhere in the full range. Heights are
	// bunched around the ground limit, with a share exactly on it.
	function automatic point_t random_point();
		point_t      p;
		longint      step;
		longint      span;
		int unsigned pick;
		step = (cell_edge == '0) ? 64'sd1 : longint'(cell_edge);
		pick = $urandom_range(0, 99);
		span = (pick < 70) ? 4 * step : 256 * step;
		if (span > longint'(COORD_MAX)) begin
			span = longint'(COORD_MAX);
		end
		if (pick >= 85) begin
			p.x = $urandom;
			p.y = $urandom;
		end else begin
			p.x = near_value(0, span);
			p.y = near_value(0, span);
		end
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			p.z = ground_limit;
		end else if (pick < 70) begin
			p.z = near_value(longint'(ground_limit), 4 * ONE_METER);
		end else begin
			p.z = $urandom;
		end
		p.fend = ($urandom_range(0, 39) == 0);
		return p;
	endfunction

	// Sends one point and records its labeling once the point transaction is taken.
	// Valid stays high into the next call inside a burst; a gap lowers it first.
	task automatic send_point(input point_t p);
		int unsigned gap;
		point_valid <= 1'b1;
		pos_x       <= p.x;
		pos_y       <= p.y;
		pos_z       <= p.z;
		frame_end   <= p.fend;
		@(posedge clk);
		while (point_stall) begin
			@(posedge clk);
		end
		pending_labels.insert(pending_labels.size(), label_point(p));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap        = quiet_mode ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				point_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Holds the sender back until every labeling has come back and the block is idle.
	task automatic wait_idle();
		point_valid <= 1'b0;
		while (pending_labels.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// One register write; only called with the block idle.
	task automatic write_register(input gcpl_pkg::cfg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == gcpl_pkg::REG_GROUND_LIMIT) begin
			ground_limit = value;
		end else if (idx == gcpl_pkg::REG_CELL_SIZE) begin
			cell_edge = value[gcpl_pkg::SIZE_W-1:0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset values, floor rounding on both sides of zero, exact multiples, index
	// extremes, heights on the limit and at both ends of the range, and a frame that ends.
	task automatic test_grid_boundaries();
		quiet_mode = 1'b1;
		send_point(make_point(0, 0, 0, 1'b0));
		send_point(make_point(0, 0, 1, 1'b0));
		send_point(make_point(32'sh0000_FFFF, 32'sh0000_8000, 1, 1'b0));
		send_point(make_point(-1, 0, 1, 1'b0));
		send_point(make_point(-32'sd65536, 0, 1, 1'b0));
		send_point(make_point(-32'sd65537, 32'sh0000_FFFF, 1, 1'b0));
		send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0));
		send_point(make_point(0, 0, COORD_MIN, 1'b0));
		send_point(make_point(COORD_MIN, COORD_MAX, 2, 1'b1));
		quiet_mode = 1'b0;
	endtask

	// Zero cell size behaves as the smallest step, writes to spare indexes are dropped,
	// and both registers go to their extremes.
	task automatic test_register_extremes();
		wait_idle();
		write_register(gcpl_pkg::REG_CELL_SIZE, 32'h0);
		write_register(REG_SPARE_A, 32'hFFFF_FFFF);
		write_register(REG_SPARE_B, 32'h8000_0001);
		send_point(make_point(32'sd32768, 0, 1, 1'b0));
		send_point(make_point(32'sd32767, 0, 1, 1'b0));
		send_point(make_point(-32'sd32769, -32'sd32768, 1, 1'b0));
		send_point(make_point(COORD_MIN, COORD_MAX, 1, 1'b0));
		send_point(make_point(5, -5, 5, 1'b1));

		wait_idle();
		write_register(gcpl_pkg::REG_GROUND_LIMIT, COORD_MAX);
		send_point(make_point(1, 1, COORD_MAX, 1'b0));
		send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));

		wait_idle();
		write_register(gcpl_pkg::REG_GROUND_LIMIT, COORD_MIN);
		write_register(gcpl_pkg::REG_CELL_SIZE, {1'b0, SIZE_MAX});
		send_point(make_point(COORD_MAX, 0, COORD_MIN, 1'b0));
		send_point(make_point(COORD_MAX, COORD_MAX - 1, COORD_MIN + 1, 1'b0));
		send_point(make_point(COORD_MIN, -1, COORD_MAX, 1'b0));
		send_point(make_point(COORD_MAX - 1, COORD_MIN + 1, 0, 1'b1));
	endtask

	// Fills many table rows with distinct cells in one frame, then checks that new
	// cells still take the next ids while known ones, first and last, keep theirs.
	task automatic test_table_fill();
		int     i;
		longint cx;
		longint cy;
		point_t first_pt;
		point_t last_pt;
		wait_idle();
		write_register(gcpl_pkg::REG_GROUND_LIMIT, 32'h0);
		write_register(gcpl_pkg::REG_CELL_SIZE, 32'(ONE_METER));
		for (i = 0; i < 320; i++) begin
			cx = (i % 32) - 16;
			cy = (i / 32) - 5;
			last_pt = make_point(32'(cx * ONE_METER + $urandom_range(0, 65535)),
				32'(cy * ONE_METER + $urandom_range(0, 65535)),
				32'($urandom_range(1, 32'h7FFF_FFFF)), 1'b0);
			if (i == 0) begin
				first_pt = last_pt;
			end
			send_point(last_pt);
			// Now and then a ground point and a revisit of the first cell.
			if (i % 64 == 63) begin
				send_point(make_point($urandom, $urandom, -32'sd1, 1'b0));
				send_point(first_pt);
			end
		end
		send_point(make_point(32'sd100 * 65536, 0, 1, 1'b0));
		send_point(make_point(0, -32'sd100 * 65536, 1, 1'b0));
		send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
		send_point(first_pt);
		send_point(last_pt);
		send_point(make_point(0, 0, 0, 1'b0));
		send_point(make_point(COORD_MIN, COORD_MIN, 1, 1'b1));
		// The frame is cleared: the same cell starts again at id 1.
		send_point(make_point(COORD_MIN, COORD_MIN, 1, 1'b1));
	endtask

	// One random phase under a given setting of both registers.
	task automatic run_random_phase(input logic [31:0] limit, input logic [31:0] edge_len,
			input int unsigned count, input bit quiet);
		int unsigned n;
		wait_idle();
		write_register(gcpl_pkg::REG_GROUND_LIMIT, limit);
		write_register(gcpl_pkg::REG_CELL_SIZE, edge_len);
		quiet_mode = quiet;
		for (n = 0; n < count; n++) begin
			// Once in a while the sender drains the block completely.
			if ($urandom_range(0, 99) == 0) begin
				wait_idle();
			end
			send_point(random_point());
		end
		quiet_mode = 1'b0;
	endtask

	task automatic test_random_frames();
		run_random_phase(32'h0, 32'(ONE_METER), 150, 1'b0);
		run_random_phase(32'($urandom_range(0, 10 * 65536)) - 32'(5 * 65536),
			$urandom_range(1, 32'h0010_0000), 90, 1'b0);
		run_random_phase(COORD_MIN, 32'h1, 70, 1'b1);
		run_random_phase($urandom, $urandom, 70, 1'b0);
		run_random_phase(COORD_MAX, 32'h0, 30, 1'b0);
		run_random_phase(32'h0, {1'b0, SIZE_MAX}, 30, 1'b0);
	endtask

	initial begin
		arst_n       = 1'b0;
		point_valid  = 1'b0;
		pos_x        = '0;
		pos_y        = '0;
		pos_z        = '0;
		frame_end    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = gcpl_pkg::REG_GROUND_LIMIT;
		cfg_data     = '0;
		ground_limit = gcpl_pkg::GROUND_LIMIT_RESET;
		cell_edge    = gcpl_pkg::CELL_SIZE_RESET;
		cells_used   = 0;
		ground_seen  = '0;
		burst_left   = 0;
		quiet_mode   = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_grid_boundaries();
		test_register_extremes();
		test_table_fill();
		test_random_frames();

		// Drain, then give the block time to show any result that it should not send.
		wait_idle();
		repeat (50) @(posedge clk);
		if (pending_labels.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d labelings never arrived", $time, pending_labels.size());
		end
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
